@@ rtl/hashed_process_uuid_macros.svh @@
// Assertion macros used by the back end of the process UUID hasher.
`ifndef HASHED_PROCESS_UUID_MACROS_SVH
`define HASHED_PROCESS_UUID_MACROS_SVH

`ifndef SYNTH
// Checked property, ignored while reset is held.
`define HPU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also during reset.
`define HPU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPU_ASSERT(lbl, clk, rstn, prop, msg)
`define HPU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/hpu_pkg.sv @@
// Types, constants and SHA-256 helper functions for the process UUID hasher.
package hpu_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7]  hstate_t;
  typedef word_t [0:15] msg_t;
  typedef logic [127:0] uuid_t;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_ID_HIGH = 1'b0,
    REG_BOOT_ID_LOW  = 1'b1
  } cfg_reg_t;

  localparam int MSG_BYTES  = 40;
  localparam int ROUNDS     = 64;
  localparam int LAST       = ROUNDS - 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  localparam logic [7:0] VER_MASK = 8'h0F;
  localparam logic [7:0] VER_BITS = 8'h80;
  localparam logic [7:0] VAR_MASK = 8'h3F;
  localparam logic [7:0] VAR_BITS = 8'h80;

  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam word_t LEN_WORD = 32'(MSG_BYTES * 8);

  localparam hstate_t INIT_H = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int n);
    return word_t'({x, x} >> n);
  endfunction

  function automatic word_t bswap(word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // One compression round; element 0 is a, element 7 is h.
  function automatic hstate_t sha_round(hstate_t s, word_t k, word_t w);
    word_t   a;
    word_t   e;
    word_t   t1;
    word_t   t2;
    hstate_t r;
    a  = s[0];
    e  = s[4];
    t1 = s[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & s[5]) ^ (~e & s[6])) + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = s[3] + t1;
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = t1 + t2;
    return r;
  endfunction

  // Slide the 16-word schedule window by one and append the next word.
  function automatic msg_t sched_shift(msg_t win);
    word_t s0;
    word_t s1;
    msg_t  r;
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    for (int j = 0; j < 15; j++) begin
      r[j] = win[j + 1];
    end
    r[15] = win[0] + s0 + win[9] + s1;
    return r;
  endfunction

  // Final add of the first four digest words, then version and variant bits.
  function automatic uuid_t make_uuid(hstate_t s);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {s[0] + INIT_H[0], s[1] + INIT_H[1]};
    lo = {s[2] + INIT_H[2], s[3] + INIT_H[3]};
    hi[15:8]  = (hi[15:8] & VER_MASK) | VER_BITS;
    lo[63:56] = (lo[63:56] & VAR_MASK) | VAR_BITS;
    return {hi, lo};
  endfunction

endpackage

@@ rtl/hashed_process_uuid.sv @@
// Top level: SHA-256 name-based process UUID (version 8 layout), one request per cycle while full is low.
// Throughput: one request per clock while not stalled; the 64-stage round pipeline takes a new block every cycle.
// The path from the accepting edge until empty falls runs through the front register, the queue,
//   the 64 round stages and the result buffer; it is longer only while pop is held low.
// Reset (rst_n low at a clock edge): clear all valid flags, queue and buffer counts, and both
//   boot id registers to zero; there is no clearing pass, the block is ready right after.
module hashed_process_uuid import hpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  // request side
  input  logic                 push,
  output logic                 full,
  input  logic [63:0]          in_namespace_id,
  input  logic [63:0]          in_start_ticks,
  input  logic signed [31:0]   in_group_id,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          out_uuid_high,
  output logic [63:0]          out_uuid_low
);

  // Front to queue: one formatted 512-bit padded block per request.
  logic q_push;
  logic q_full;
  msg_t q_wr_data;

  // Queue to back end.
  logic q_pop;
  logic q_empty;
  msg_t q_rd_data;

  // The front end holds the boot id and builds the padded message:
  // boot id bytes, then the three values little-endian, pad byte and bit length.
  hpu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_namespace_id (in_namespace_id),
    .in_start_ticks  (in_start_ticks),
    .in_group_id     (in_group_id),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_data          (q_wr_data)
  );

  // A four-entry queue decouples the front end from a stalled pipeline,
  // so requests keep flowing while the result side drains.
  hpu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_push  (q_push),
    .wr_full  (q_full),
    .wr_data  (q_wr_data),
    .rd_pop   (q_pop),
    .rd_empty (q_empty),
    .rd_data  (q_rd_data)
  );

  // The back end runs one compression round per stage, with the message
  // schedule window carried alongside, then adds the initial hash, sets the
  // version and variant bits and parks the UUID in a two-entry result buffer.
  hpu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rd_data),
    .empty         (empty),
    .pop           (pop),
    .out_uuid_high (out_uuid_high),
    .out_uuid_low  (out_uuid_low)
  );

endmodule

@@ rtl/hpu_front.sv @@
// Front end: boot id registers, request capture and padded block formatting.
module hpu_front import hpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [63:0]          in_namespace_id,
  input  logic [63:0]          in_start_ticks,
  input  logic signed [31:0]   in_group_id,
  output logic                 q_push,
  input  logic                 q_full,
  output msg_t                 q_data
);

  logic [63:0] boot_hi_r, boot_hi_nxt;
  logic [63:0] boot_lo_r, boot_lo_nxt;
  logic        vld_r, vld_nxt;
  msg_t        blk_r;
  msg_t        blk_nxt;
  logic        accept;

  always_comb begin
    boot_hi_nxt = boot_hi_r;
    boot_lo_nxt = boot_lo_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOOT_ID_HIGH: boot_hi_nxt = cfg_data;
        REG_BOOT_ID_LOW:  boot_lo_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the request while the queue is full.
  assign full   = vld_r && q_full;
  assign accept = push && !full;
  assign q_push = vld_r;
  assign q_data = blk_r;

  always_comb begin
    blk_nxt     = '0;
    blk_nxt[0]  = boot_hi_r[63:32];
    blk_nxt[1]  = boot_hi_r[31:0];
    blk_nxt[2]  = boot_lo_r[63:32];
    blk_nxt[3]  = boot_lo_r[31:0];
    blk_nxt[4]  = bswap(in_namespace_id[31:0]);
    blk_nxt[5]  = bswap(in_namespace_id[63:32]);
    blk_nxt[6]  = bswap(in_start_ticks[31:0]);
    blk_nxt[7]  = bswap(in_start_ticks[63:32]);
    blk_nxt[8]  = bswap(in_group_id);
    blk_nxt[9]  = {32{in_group_id[31]}};
    blk_nxt[10] = PAD_WORD;
    blk_nxt[15] = LEN_WORD;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push && !q_full) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_hi_r <= '0;
      boot_lo_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      boot_hi_r <= boot_hi_nxt;
      boot_lo_r <= boot_lo_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

@@ rtl/hpu_queue.sv @@
// Short block queue between the front end and the round pipeline.
module hpu_queue import hpu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_push,
  output logic wr_full,
  input  msg_t wr_data,
  input  logic rd_pop,
  output logic rd_empty,
  output msg_t rd_data
);

  msg_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign wr_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign rd_empty = (cnt_r == '0);
  assign do_wr    = wr_push && !wr_full;
  assign do_rd    = rd_pop && !rd_empty;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/hpu_back.sv @@
// Back end: 64-stage SHA-256 round pipeline, UUID shaping and result buffer.
`include "hashed_process_uuid_macros.svh"
module hpu_back import hpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  output logic        q_pop,
  input  msg_t        q_data,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_uuid_high,
  output logic [63:0] out_uuid_low
);

  logic    vld_r [ROUNDS];
  hstate_t st_r  [ROUNDS];
  msg_t    win_r [ROUNDS];
  logic    adv;

  uuid_t                 obuf_r [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [OBUF_PTR_W-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [OBUF_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                  obuf_full;
  logic                  obuf_push;
  logic                  obuf_pop;

  // Advance the whole pipeline unless a finished request is blocked.
  assign obuf_full = (ocnt_r == OBUF_CNT_W'(OBUF_DEPTH));
  assign adv       = !(vld_r[LAST] && obuf_full);
  assign q_pop     = adv && !q_empty;

  for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
    hstate_t st_in;
    msg_t    win_in;
    logic    vld_in;

    if (s == 0) begin : g_head
      assign st_in  = INIT_H;
      assign win_in = q_data;
      assign vld_in = !q_empty;
    end else begin : g_body
      assign st_in  = st_r[s-1];
      assign win_in = win_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s]  <= sha_round(st_in, K_TABLE[s], win_in[0]);
        win_r[s] <= sched_shift(win_in);
      end
    end
  end

  assign obuf_push = adv && vld_r[LAST];
  assign obuf_pop  = pop && !empty;
  assign empty     = (ocnt_r == '0);
  assign {out_uuid_high, out_uuid_low} = obuf_r[ord_ptr_r];

  always_comb begin
    owr_ptr_nxt = obuf_push ? owr_ptr_r + 1'b1 : owr_ptr_r;
    ord_ptr_nxt = obuf_pop ? ord_ptr_r + 1'b1 : ord_ptr_r;
    ocnt_nxt    = ocnt_r;
    if (obuf_push && !obuf_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (obuf_pop && !obuf_push) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (obuf_push) begin
      obuf_r[owr_ptr_r] <= make_uuid(st_r[LAST]);
    end
  end

  `HPU_ASSERT(a_stall_holds, clk, rst_n, (vld_r[LAST] && !adv) |=> (vld_r[LAST] && $stable(st_r[LAST])), "blocked request lost or changed")
  `HPU_ASSERT(a_pop_enters, clk, rst_n, q_pop |=> vld_r[0], "popped block did not enter round pipeline")
  `HPU_ASSERT(a_obuf_count, clk, rst_n, (obuf_push && !obuf_pop) |=> (ocnt_r == $past(ocnt_r) + 1'b1), "result buffer count slip")
  `HPU_ASSERT_ALWAYS(a_obuf_bound, clk, !rst_n || ocnt_r <= OBUF_CNT_W'(OBUF_DEPTH), "result buffer overfilled")

endmodule
